// ===== hdl/chdt_pkg.sv =====
// Shared types, command and status codes and constants of the capture history table.
package chdt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam logic [15:0] WINDOW_RESET = 16'd500;
  localparam logic [15:0] REPEAT_MAX   = 16'hFFFF;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_DEDUP  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SUPPRESSED = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd3;

  localparam int         PADDR_W    = 3;
  localparam logic [0:0] REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] frame_hash;
    logic [7:0]  protocol_id;
    logic [31:0] tick_ms;
    logic [5:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] repeat_count;
    logic [6:0]  entry_count_out;
    logic [31:0] read_hash;
    logic [7:0]  read_protocol;
  } res_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [7:0]  protocol;
    logic [15:0] repeats;
  } entry_t;

endpackage

// ===== hdl/capture_history_dedup_table.sv =====
// Top level of the capture history table with repeat suppression and de-duplication.
//
// Commands enter on the cmd channel (cmd_valid, cmd_stall, cmd) and each gives exactly one
// word on the res channel (res_valid, res_stall, res). A word is taken at a clock edge with
// valid high and stall low. One command is worked at a time; cmd_stall is high from the
// edge that takes a command until its result has been handed to the output register.
// Work per command, n being the entry count before it:
//   add:  scans the entries newest first for an earlier copy and stops at a match; no scan
//         when the frame is suppressed or the table is full.
//   delete at index i: shifts the n - i - 1 entries above i down.  read: one memory read.
//   clear, bad index, unknown code: no memory access.
//   remove duplicates: compares each entry with the later entries until a match.
// The single read port of the entry memory delivers one entry per cycle, in the cycle
// after its address. A result that the receiver stalls stays in the output register while
// the next command is taken and worked; that command's result is held back until the
// register is free.
// Reset (rst, synchronous) empties the table, zeroes the last hash and its timer and sets
// the suppression window to 500 ms; the entry memory itself is not cleared.
// The window is written over the APB port at byte address 0; pready is always high.
module capture_history_dedup_table
  import chdt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0]   window;
  logic          reg_sel;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  assign reg_sel = (paddr[PADDR_W-1] == REG_WINDOW);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'd0, window} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window <= pwdata[15:0];
    end
  end

  chdt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .window   (window),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  chdt_mem #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ===== hdl/chdt_mem.sv =====
// Entry memory: one write port and one read port with registered read data.
module chdt_mem
  import chdt_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/chdt_ctrl.sv =====
// Command sequencer: walks the entry memory for add, delete, de-duplicate and read.
module chdt_ctrl
  import chdt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  cmd_t          cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output res_t          res,
  input  logic [15:0]   window,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_ADD_SCAN  = 7'b0000010,
    S_DEL_SHIFT = 7'b0000100,
    S_DED_LOAD  = 7'b0001000,
    S_DED_KEY   = 7'b0010000,
    S_DED_SCAN  = 7'b0100000,
    S_READ      = 7'b1000000
  } state_t;

  // A finished result also waits in the idle state family via done.
  state_t        state, state_next;
  logic          done, done_next;
  cmd_t          req, req_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   last_hash, last_hash_next;
  logic [31:0]   last_time, last_time_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] m, m_next;
  logic [CW-1:0] w, w_next;
  logic          pend, pend_next;
  entry_t        key, key_next;
  logic [2:0]    stat, stat_next;
  logic [15:0]   reps, reps_next;
  logic [31:0]   rhash, rhash_next;
  logic [7:0]    rproto, rproto_next;
  logic          res_valid_next;
  res_t          res_next;

  logic          take;
  logic          idx_ok;
  logic          suppress;
  logic          add_hit;
  logic          ded_hit;
  logic [15:0]   add_reps;
  logic [CW-1:0] k_dec;
  logic [31:0]   elapsed;
  logic          slot_free;

  assign cmd_stall = (state != S_IDLE) || done;
  assign take      = cmd_valid && !cmd_stall;
  assign slot_free = !res_valid || !res_stall;

  assign idx_ok   = IW'(cmd.entry_index) < IW'(count);
  assign elapsed  = cmd.tick_ms - last_time;
  assign suppress = (cmd.frame_hash == last_hash) && (elapsed < {16'd0, window});
  assign add_hit  = pend && (mem_rdata.hash == req.frame_hash) &&
                    (mem_rdata.protocol == req.protocol_id);
  assign ded_hit  = pend && (mem_rdata.hash == key.hash) &&
                    (mem_rdata.protocol == key.protocol);
  assign add_reps = (mem_rdata.repeats == REPEAT_MAX) ? REPEAT_MAX
                                                      : mem_rdata.repeats + 16'd1;
  assign k_dec    = k - CW'(1);

  always_comb begin
    state_next     = state;
    done_next      = done;
    req_next       = req;
    count_next     = count;
    last_hash_next = last_hash;
    last_time_next = last_time;
    k_next         = k;
    m_next         = m;
    w_next         = w;
    pend_next      = pend;
    key_next       = key;
    stat_next      = stat;
    reps_next      = reps;
    rhash_next     = rhash;
    rproto_next    = rproto;
    res_valid_next = res_valid;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = key;
    mem_raddr      = '0;

    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (done) begin
          if (slot_free) begin
            res_valid_next           = 1'b1;
            res_next.status          = stat;
            res_next.repeat_count    = reps;
            res_next.entry_count_out = 7'(count);
            res_next.read_hash       = rhash;
            res_next.read_protocol   = rproto;
            done_next                = 1'b0;
          end
        end else if (take) begin
          req_next    = cmd;
          stat_next   = ST_OK;
          reps_next   = '0;
          rhash_next  = '0;
          rproto_next = '0;
          pend_next   = 1'b0;
          done_next   = 1'b1;
          case (cmd.command)
            CMD_ADD: begin
              if (count >= CW'(TABLE_DEPTH)) begin
                stat_next = ST_FULL;
              end else if (suppress) begin
                last_time_next = cmd.tick_ms;
                stat_next      = ST_SUPPRESSED;
              end else begin
                k_next     = count;
                done_next  = 1'b0;
                state_next = S_ADD_SCAN;
              end
            end
            CMD_DELETE: begin
              if (idx_ok) begin
                k_next     = CW'(cmd.entry_index);
                m_next     = CW'(cmd.entry_index) + CW'(1);
                done_next  = 1'b0;
                state_next = S_DEL_SHIFT;
              end else begin
                stat_next = ST_BAD_INDEX;
              end
            end
            CMD_CLEAR: begin
              count_next     = '0;
              last_hash_next = '0;
            end
            CMD_DEDUP: begin
              k_next     = '0;
              w_next     = '0;
              done_next  = 1'b0;
              state_next = S_DED_LOAD;
            end
            CMD_READ: begin
              if (idx_ok) begin
                mem_raddr  = AW'(cmd.entry_index);
                done_next  = 1'b0;
                state_next = S_READ;
              end else begin
                stat_next = ST_BAD_INDEX;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Newest-first search; a read is issued every cycle and its data checked in the following cycle.
      S_ADD_SCAN: begin
        if (add_hit || (!pend && (k == '0))) begin
          mem_we             = 1'b1;
          mem_waddr          = count[AW-1:0];
          mem_wdata.hash     = req.frame_hash;
          mem_wdata.protocol = req.protocol_id;
          mem_wdata.repeats  = add_hit ? add_reps : 16'd0;
          reps_next          = add_hit ? add_reps : 16'd0;
          count_next         = count + CW'(1);
          last_hash_next     = req.frame_hash;
          last_time_next     = req.tick_ms;
          pend_next          = 1'b0;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end else if (k != '0) begin
          mem_raddr = k_dec[AW-1:0];
          k_next    = k_dec;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end

      // Shift down: k is the write slot, m the next slot to read; they never coincide.
      S_DEL_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = k[AW-1:0];
          mem_wdata = mem_rdata;
          k_next    = k + CW'(1);
        end
        if (m < count) begin
          mem_raddr = m[AW-1:0];
          m_next    = m + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - CW'(1);
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_DED_LOAD: begin
        if (k >= count) begin
          count_next = w;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_raddr  = k[AW-1:0];
          state_next = S_DED_KEY;
        end
      end

      S_DED_KEY: begin
        key_next   = mem_rdata;
        m_next     = k + CW'(1);
        pend_next  = 1'b0;
        state_next = S_DED_SCAN;
      end

      // Entry k survives only if no later entry has its hash and protocol.
      // The compacted write slot w never passes k, so unread entries stay intact.
      S_DED_SCAN: begin
        if (ded_hit || (!pend && (m >= count))) begin
          if (!ded_hit) begin
            mem_we    = 1'b1;
            mem_waddr = w[AW-1:0];
            mem_wdata = key;
            w_next    = w + CW'(1);
          end
          k_next     = k + CW'(1);
          pend_next  = 1'b0;
          state_next = S_DED_LOAD;
        end else if (m < count) begin
          mem_raddr = m[AW-1:0];
          m_next    = m + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_READ: begin
        reps_next   = mem_rdata.repeats;
        rhash_next  = mem_rdata.hash;
        rproto_next = mem_rdata.protocol;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= '0;
      last_hash <= '0;
      last_time <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      count     <= count_next;
      last_hash <= last_hash_next;
      last_time <= last_time_next;
      pend      <= pend_next;
      res_valid <= res_valid_next;
    end
    req    <= req_next;
    k      <= k_next;
    m      <= m_next;
    w      <= w_next;
    key    <= key_next;
    stat   <= stat_next;
    reps   <= reps_next;
    rhash  <= rhash_next;
    rproto <= rproto_next;
    res    <= res_next;
  end

endmodule

// ===== hdl/chdt_check.sv =====
// Port checker for the capture history table and its bind to the top level.
module chdt_check
  import chdt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // A stalled result word must hold.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Commands are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second command taken straight after the first");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.entry_count_out) <= TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Only a read returns entry data; a suppressed add returns nothing else.
  a_suppressed_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_SUPPRESSED) |->
      (res.read_hash == 32'd0) && (res.read_protocol == 8'd0) &&
      (res.repeat_count == 16'd0))
    else $error("suppressed add carries data");

endmodule

bind capture_history_dedup_table chdt_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_check (.*);
